### hw/rtl/servo_bus_reply_frame_receiver_unit_macros.svh
// Assertion macros for the servo bus reply frame receiver.
`ifndef SERVO_BUS_REPLY_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SERVO_BUS_REPLY_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTH

// Implication check, disabled while reset is asserted.
`define SBRFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sbrfr assertion failed");

// Condition that must never be seen at a clock edge.
`define SBRFR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sbrfr forbidden condition seen");

`else

`define SBRFR_ASSERT(lbl, clk, rst_n, prop)
`define SBRFR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/sbrfr_pkg.sv
// Types and constants shared by the servo bus reply frame receiver.
package sbrfr_pkg;

	// Command codes of an input beat.
	localparam logic [1:0] CMD_ARM  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Result status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

	localparam logic [7:0]  HDR_BYTE      = 8'h55;
	localparam logic [7:0]  MIN_LEN_EXCL  = 8'd3;
	localparam logic [15:0] TIMEOUT_RESET = 16'd200;

	localparam int LEN_W    = 4;
	localparam int TICK_W   = 16;
	localparam int NPARAM   = 4;
	localparam int FIRST_PARAM = 3;

	// APB register map.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] expected_id;
		logic [7:0] expected_command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic             status;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       param_byte0;
		logic [7:0]       param_byte1;
		logic [7:0]       param_byte2;
		logic [7:0]       param_byte3;
	} result_t;

	// Control from the beat register to the parser.
	typedef struct packed {
		logic valid;
		logic step;
	} step_ctl_t;

	// Receiver state, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HDR0 = 4'b0010,
		ST_HDR1 = 4'b0100,
		ST_BODY = 4'b1000
	} rx_state_t;

endpackage

### hw/rtl/servo_bus_reply_frame_receiver_unit.sv
// Servo bus reply frame receiver: beat register, parser, result register, APB register.
// An accepted beat is held in the beat register; its result is then registered in the result register.
// Throughput: one beat per cycle; the beat register and the result register both
//   advance every cycle unless a finished result is held by result_ready.
// Reset (arst_n low, asynchronous): receiver idle and disarmed, both registers
//   empty, timeout_ticks back to 200. The frame store is not cleared.
module servo_bus_reply_frame_receiver_unit #(
	parameter int MAX_FRAME = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            item_valid,
	output logic                            item_ready,
	input  sbrfr_pkg::item_t                item,
	// result beats
	output logic                            result_valid,
	input  logic                            result_ready,
	output sbrfr_pkg::result_t              result,
	// APB register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbrfr_pkg::PADDR_W-1:0]   paddr,
	input  logic [sbrfr_pkg::PDATA_W-1:0]   pwdata,
	output logic [sbrfr_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);

`include "servo_bus_reply_frame_receiver_unit_macros.svh"

	// Timeout register, bits [15:0] at offset 0.
	logic [sbrfr_pkg::TICK_W-1:0] timeout_q;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == sbrfr_pkg::REG_TIMEOUT);
	assign prdata  = reg_sel ? sbrfr_pkg::PDATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbrfr_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata[sbrfr_pkg::TICK_W-1:0];
		end
	end

	// Stage 1: the accepted beat waits here while the parser works on it.
	logic                  s1_valid_q;
	sbrfr_pkg::item_t      item_s1;
	sbrfr_pkg::step_ctl_t  ctl;
	logic                  hit;
	sbrfr_pkg::result_t    res;
	logic                  out_free;
	logic                  advance;

	// Result slot is free when empty or being drained this cycle.
	assign out_free   = !result_valid || result_ready;
	// A beat that yields no result never waits on the output side.
	assign advance    = s1_valid_q && (!hit || out_free);
	assign item_ready = !s1_valid_q || advance;
	assign ctl        = '{valid: s1_valid_q, step: advance};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	sbrfr_parser #(
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.hit           (hit),
		.res           (res)
	);

	// Stage 2: result register, held until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (result_valid && !result_ready) || (advance && hit);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			result <= res;
		end
	end

	// A held beat is never dropped.
	`SBRFR_ASSERT(a_s1_hold, clk, arst_n, (s1_valid_q && !advance) |=> s1_valid_q)
	// Only a received byte or a tick can finish a frame.
	`SBRFR_ASSERT(a_hit_src, clk, arst_n,
		hit |-> (s1_valid_q && (item_s1.cmd == sbrfr_pkg::CMD_BYTE ||
		item_s1.cmd == sbrfr_pkg::CMD_TICK)))
	// A good frame has at least id, length, command, one more byte and checksum.
	`SBRFR_ASSERT(a_len_ok, clk, arst_n,
		(result_valid && result.status == sbrfr_pkg::STATUS_OK) |->
		(result.frame_length >= 4'd5 &&
		result.frame_length <= sbrfr_pkg::LEN_W'(MAX_FRAME)))
	// A timeout never reports frame content.
	`SBRFR_NEVER(a_tmo_clean, clk, arst_n,
		result_valid && result.status == sbrfr_pkg::STATUS_TIMEOUT &&
		result.frame_length != '0)

endmodule

### hw/rtl/sbrfr_parser.sv
// Frame parser: receiver state, frame store and the per-beat result logic.
module sbrfr_parser #(
	parameter int MAX_FRAME = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbrfr_pkg::step_ctl_t           ctl,
	input  sbrfr_pkg::item_t               item,
	input  logic [sbrfr_pkg::TICK_W-1:0]   timeout_ticks,
	output logic                           hit,
	output sbrfr_pkg::result_t             res
);

	localparam int POS_W = $clog2(MAX_FRAME + 1);
	localparam int IDX_W = $clog2(MAX_FRAME);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);
	localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 1);

	sbrfr_pkg::rx_state_t state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d, pn;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        dl_q, dl_d;
	logic [7:0]        want_id_q, want_id_d;
	logic [7:0]        want_cmd_q, want_cmd_d;
	logic [sbrfr_pkg::TICK_W-1:0] idle_q, idle_d, idle_nx;
	logic [7:0]        store_q [MAX_FRAME];
	logic              store_we;
	logic              bad;
	logic [8:0]        dl_plus1, pn_ext;
	logic [7:0]        pb [sbrfr_pkg::NPARAM];
	logic [7:0]        d;

	assign d        = item.rx_byte;
	assign pn       = pos_q + POS_W'(1);
	assign pn_ext   = 9'(pn);
	assign dl_plus1 = {1'b0, dl_q} + 9'd1;
	assign idle_nx  = (idle_q != '1) ? idle_q + sbrfr_pkg::TICK_W'(1) : idle_q;

	// Parameter bytes of a finished frame; positions past the frame's payload or past the store read zero.
	for (genvar k = 0; k < sbrfr_pkg::NPARAM; k++) begin : g_param
		if (sbrfr_pkg::FIRST_PARAM + k < MAX_FRAME) begin : g_in
			assign pb[k] = (8'(sbrfr_pkg::FIRST_PARAM + k) < dl_q) ?
				store_q[sbrfr_pkg::FIRST_PARAM + k] : 8'h00;
		end else begin : g_out
			assign pb[k] = 8'h00;
		end
	end

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		sum_d      = sum_q;
		dl_d       = dl_q;
		want_id_d  = want_id_q;
		want_cmd_d = want_cmd_q;
		idle_d     = idle_q;
		store_we   = 1'b0;
		bad        = 1'b0;
		hit        = 1'b0;
		res        = '0;
		if (ctl.valid) begin
			unique case (item.cmd)
				sbrfr_pkg::CMD_ARM: begin
					want_id_d  = item.expected_id;
					want_cmd_d = item.expected_command;
					state_d    = sbrfr_pkg::ST_HDR0;
					idle_d     = '0;
					pos_d      = '0;
					sum_d      = '0;
				end
				sbrfr_pkg::CMD_BYTE: begin
					if (state_q != sbrfr_pkg::ST_IDLE) begin
						idle_d = '0;
					end
					unique case (state_q)
						sbrfr_pkg::ST_IDLE: begin
						end
						sbrfr_pkg::ST_HDR0: begin
							state_d = (d == sbrfr_pkg::HDR_BYTE) ?
								sbrfr_pkg::ST_HDR1 : sbrfr_pkg::ST_HDR0;
							pos_d = '0;
							sum_d = '0;
						end
						sbrfr_pkg::ST_HDR1: begin
							state_d = (d == sbrfr_pkg::HDR_BYTE) ?
								sbrfr_pkg::ST_BODY : sbrfr_pkg::ST_HDR0;
							pos_d = '0;
							sum_d = '0;
						end
						sbrfr_pkg::ST_BODY: begin
							if (pos_q >= POS_MAX) begin
								bad = 1'b1;
							end else begin
								store_we = 1'b1;
								pos_d    = pn;
								priority if (pn == POS_W'(1)) begin
									bad = (d != want_id_q);
								end else if (pn == POS_W'(2)) begin
									bad  = (d <= sbrfr_pkg::MIN_LEN_EXCL) || (d > LEN_MAX);
									dl_d = d;
								end else if (pn == POS_W'(3)) begin
									bad = (d != want_cmd_q);
								end else if (pn_ext == dl_plus1) begin
									if (d == sum_q) begin
										hit              = 1'b1;
										res.status       = sbrfr_pkg::STATUS_OK;
										res.frame_length = sbrfr_pkg::LEN_W'(pn);
										res.param_byte0  = pb[0];
										res.param_byte1  = pb[1];
										res.param_byte2  = pb[2];
										res.param_byte3  = pb[3];
										state_d          = sbrfr_pkg::ST_IDLE;
										pos_d            = '0;
										sum_d            = '0;
									end else begin
										bad = 1'b1;
									end
								end else if (pn_ext > dl_plus1) begin
									bad = 1'b1;
								end else begin
								end
								if (!hit && !bad) begin
									sum_d = sum_q + d;
								end
							end
							if (bad) begin
								state_d = sbrfr_pkg::ST_HDR0;
								pos_d   = '0;
								sum_d   = '0;
							end
						end
						default: begin
						end
					endcase
				end
				sbrfr_pkg::CMD_TICK: begin
					if (state_q != sbrfr_pkg::ST_IDLE) begin
						idle_d = idle_nx;
						if (idle_nx >= timeout_ticks) begin
							hit        = 1'b1;
							res.status = sbrfr_pkg::STATUS_TIMEOUT;
							state_d    = sbrfr_pkg::ST_IDLE;
							idle_d     = '0;
							pos_d      = '0;
							sum_d      = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sbrfr_pkg::ST_IDLE;
			pos_q      <= '0;
			sum_q      <= '0;
			dl_q       <= '0;
			want_id_q  <= '0;
			want_cmd_q <= '0;
			idle_q     <= '0;
		end else if (ctl.step) begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			sum_q      <= sum_d;
			dl_q       <= dl_d;
			want_id_q  <= want_id_d;
			want_cmd_q <= want_cmd_d;
			idle_q     <= idle_d;
		end
	end

	// Store holds the body bytes of the frame, id through checksum; an entry is always written before it is read.
	always_ff @(posedge clk) begin
		if (ctl.step && store_we) begin
			store_q[pos_q[IDX_W-1:0]] <= d;
		end
	end

endmodule
